### hdl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console cell writer: field widths,
// operation codes, register indexes, special characters and the structs that
// carry configuration, input transactions and results between modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // field widths
    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int COORD_W    = 8;
    localparam int POS_W      = 15;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int LIN_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ATTR   = 1'd1;

    // configuration reset values
    localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd15;
    localparam logic [ATTR_W-1:0] ERROR_ATTR_RST   = 8'd244;

    // special characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_ERROR     = 8'h45;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

    typedef struct packed {
        logic [ATTR_W-1:0] default_attr;
        logic [ATTR_W-1:0] error_attr;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [CHAR_W-1:0]  ch;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               use_cursor;
        logic [ATTR_W-1:0]  attr;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic              error;
        logic [CHAR_W-1:0] read_char;
        logic [ATTR_W-1:0] read_attr;
    } result_t;

endpackage

### hdl/tcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single write port, single read port synchronous RAM with a
// registered read. Read data holds when no read is issued.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/tcw_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_seq
// Sequencer of the console: holds the cursor, decodes one transaction at a
// time and drives the screen memory for single cell writes and reads, the
// scroll copy sweep, the clear sweep and the clearing pass after reset.
// ----------------------------------------------------------------------------
module tcw_seq #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tcw_pkg::cfg_t           cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  tcw_pkg::item_t          item,
    output logic                    res_valid,
    input  logic                    res_ready,
    output tcw_pkg::result_t        res,
    output logic                    ram_we,
    output logic [((COLS * ROWS > 1) ? $clog2(COLS * ROWS) : 1)-1:0] ram_waddr,
    output logic [tcw_pkg::CELL_W-1:0] ram_wdata,
    output logic                    ram_re,
    output logic [((COLS * ROWS > 1) ? $clog2(COLS * ROWS) : 1)-1:0] ram_raddr,
    input  logic [tcw_pkg::CELL_W-1:0] ram_rdata
);

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W  = $clog2(CELLS + 1);

    localparam logic [CNT_W-1:0]  CELLS_C = CNT_W'(CELLS);
    localparam logic [CNT_W-1:0]  LAST_C  = CNT_W'(CELLS - 1);
    localparam logic [CNT_W-1:0]  MOVE_C  = CNT_W'(CELLS - COLS);
    localparam logic [CNT_W-1:0]  COLS_C  = CNT_W'(COLS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

    localparam logic [tcw_pkg::COORD_W-1:0] COLS_B    = tcw_pkg::COORD_W'(COLS);
    localparam logic [tcw_pkg::COORD_W-1:0] ROWS_B    = tcw_pkg::COORD_W'(ROWS);
    localparam logic [tcw_pkg::COORD_W-1:0] LASTCOL_B = tcw_pkg::COORD_W'(COLS - 1);
    localparam logic [tcw_pkg::COORD_W-1:0] LASTROW_B = tcw_pkg::COORD_W'(ROWS - 1);
    localparam logic [tcw_pkg::LIN_W-1:0]   COLS_L    = tcw_pkg::LIN_W'(COLS);

    // sequencer states
    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_CLEAR  = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [tcw_pkg::COORD_W-1:0] cur_row_reg, cur_row_next;
    logic [tcw_pkg::COORD_W-1:0] cur_col_reg, cur_col_next;
    logic pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic pend_copy_reg, pend_copy_next;
    logic err_reg, err_next;

    // latched transaction
    logic [tcw_pkg::OP_W-1:0]    op_reg, op_next;
    logic [tcw_pkg::CHAR_W-1:0]  ch_reg, ch_next;
    logic [tcw_pkg::ATTR_W-1:0]  attr_reg, attr_next;
    logic                        use_cur_reg, use_cur_next;
    logic                        in_range_reg, in_range_next;
    logic [tcw_pkg::LIN_W-1:0]   linear_reg, linear_next;
    logic [tcw_pkg::COORD_W-1:0] row_reg, row_next;
    logic [tcw_pkg::COORD_W-1:0] col_reg, col_next;

    logic [tcw_pkg::LIN_W-1:0]   cur_full;
    logic [tcw_pkg::LIN_W-1:0]   lin_in;
    logic [tcw_pkg::COORD_W-1:0] t_row, t_col, n_row, n_col;
    logic [ADDR_W-1:0]           t_addr;
    logic                        wrap;
    logic [CNT_W-1:0]            scroll_src;

    // cursor cell index and input cell index
    assign cur_full = tcw_pkg::LIN_W'(cur_row_reg) * COLS_L + tcw_pkg::LIN_W'(cur_col_reg);
    assign lin_in   = tcw_pkg::LIN_W'(item.row) * COLS_L + tcw_pkg::LIN_W'(item.col);

    // target cell of a put
    assign t_row  = use_cur_reg ? cur_row_reg : row_reg;
    assign t_col  = use_cur_reg ? cur_col_reg : col_reg;
    assign t_addr = use_cur_reg ? cur_full[ADDR_W-1:0] : linear_reg[ADDR_W-1:0];

    assign scroll_src = cnt_reg + COLS_C;

    // cursor after a put, before the scroll correction
    always_comb
    begin
        n_row = t_row;
        n_col = t_col;
        priority if (ch_reg == tcw_pkg::CH_NEWLINE)
        begin
            n_row = t_row + 1'b1;
            n_col = '0;
        end
        else if (ch_reg == tcw_pkg::CH_BACKSPACE)
        begin
            n_row = t_row;
            n_col = t_col;
        end
        else if (t_col == LASTCOL_B)
        begin
            n_row = t_row + 1'b1;
            n_col = '0;
        end
        else
        begin
            n_col = t_col + 1'b1;
        end
    end

    assign wrap = (n_row == ROWS_B);

    // next state and memory control
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        pend_copy_next = pend_copy_reg;
        err_next       = err_reg;
        op_next        = op_reg;
        ch_next        = ch_reg;
        attr_next      = attr_reg;
        use_cur_next   = use_cur_reg;
        in_range_next  = in_range_reg;
        linear_next    = linear_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        in_ready       = (state_reg == ST_IDLE);
        res_valid      = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[ADDR_W-1:0];
                if (cnt_reg == LAST_C)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = item.op;
                    ch_next       = item.ch;
                    attr_next     = (item.attr == '0) ? cfg.default_attr : item.attr;
                    use_cur_next  = item.use_cursor;
                    in_range_next = (item.col < COLS_B) && (item.row < ROWS_B);
                    linear_next   = lin_in;
                    row_next      = item.row;
                    col_next      = item.col;
                    state_next    = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                err_next   = 1'b0;
                state_next = ST_DONE;
                priority if (op_reg == tcw_pkg::OP_PUT)
                begin
                    if (!use_cur_reg && !in_range_reg)
                    begin
                        // error marker at the last cell
                        ram_we    = 1'b1;
                        ram_waddr = LAST_CELL;
                        ram_wdata = {cfg.error_attr, tcw_pkg::CH_ERROR};
                        err_next  = 1'b1;
                    end
                    else
                    begin
                        if (ch_reg != tcw_pkg::CH_NEWLINE)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = t_addr;
                            ram_wdata = {attr_reg, (ch_reg == tcw_pkg::CH_BACKSPACE) ?
                                         tcw_pkg::CH_BLANK : ch_reg};
                        end
                        cur_col_next = n_col;
                        cur_row_next = wrap ? LASTROW_B : n_row;
                        if (wrap)
                        begin
                            cnt_next   = '0;
                            state_next = ST_SCROLL;
                        end
                    end
                end
                else if (op_reg == tcw_pkg::OP_READ)
                begin
                    if (in_range_reg)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = linear_reg[ADDR_W-1:0];
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                else if (op_reg == tcw_pkg::OP_CLEAR)
                begin
                    cur_row_next = '0;
                    cur_col_next = '0;
                    cnt_next     = '0;
                    state_next   = ST_CLEAR;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_SCROLL:
            begin
                // write back the cell read in the previous cycle, or a zero fill
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = pend_copy_reg ? ram_rdata : '0;
                end
                // read the cell one row below, or zero fill on the last row
                if (cnt_reg != CELLS_C)
                begin
                    ram_re         = (cnt_reg < MOVE_C);
                    ram_raddr      = scroll_src[ADDR_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = cnt_reg[ADDR_W-1:0];
                    pend_copy_next = (cnt_reg < MOVE_C);
                    cnt_next       = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[ADDR_W-1:0];
                ram_wdata = {cfg.default_attr, tcw_pkg::CH_BLANK};
                if (cnt_reg == LAST_C)
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result fields
    always_comb
    begin
        res.position  = err_reg ? linear_reg[tcw_pkg::POS_W-1:0] :
                                  cur_full[tcw_pkg::POS_W-1:0];
        res.error     = err_reg;
        res.read_char = '0;
        res.read_attr = '0;
        if ((op_reg == tcw_pkg::OP_READ) && !err_reg)
        begin
            res.read_char = ram_rdata[tcw_pkg::CHAR_W-1:0];
            res.read_attr = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            cnt_reg     <= '0;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            pend_reg    <= 1'b0;
            err_reg     <= 1'b0;
            op_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            pend_reg    <= pend_next;
            err_reg     <= err_next;
            op_reg      <= op_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        pend_copy_reg <= pend_copy_next;
        ch_reg        <= ch_next;
        attr_reg      <= attr_next;
        use_cur_reg   <= use_cur_next;
        in_range_reg  <= in_range_next;
        linear_reg    <= linear_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
    end

`ifndef SYNTHESIS
    // a pending scroll write never outlives the scroll sweep
    a_pend_in_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_SCROLL))
        else $error("scroll write pending outside scroll sweep");

    // the cursor stays on the screen between transactions
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((cur_row_reg < ROWS_B) && (cur_col_reg < COLS_B)))
        else $error("cursor off screen");

    // one transaction at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction taken while busy");

    // scroll never reads a cell it writes in the same cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write of the same cell in one cycle");
`endif

endmodule

### hdl/text_console_cell_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Text-mode console engine: a screen memory of character/attribute cells
// and a cursor, with put, read and clear operations, scroll on overflow and
// an error marker for out-of-range puts.
//
//   channel   handshake                 payload
//   -------   ------------------------  ---------------------------------------
//   input     in_valid / in_ready       op, ch, col, row, use_cursor, attr
//   output    out_valid / out_ready     position, error, read_char, read_attr
//   config    cfg_write (no wait)       cfg_index, cfg_data
//
// A put, read or no-op transaction passes the accept, execute and result steps.
// A put that scrolls adds a row copy sweep, and a clear adds a fill sweep;
// both run on the single write port of the screen memory, one cell per
// cycle. After reset a clearing pass zeroes the screen memory; in_ready
// stays low until it ends. The result register lets the next transaction
// be accepted while a result waits; a stalled output holds the sequencer
// at its result step.
// ----------------------------------------------------------------------------
module text_console_cell_writer #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_write,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input transactions
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [tcw_pkg::OP_W-1:0]          op,
    input  logic [tcw_pkg::CHAR_W-1:0]        ch,
    input  logic [tcw_pkg::COORD_W-1:0]       col,
    input  logic [tcw_pkg::COORD_W-1:0]       row,
    input  logic                              use_cursor,
    input  logic [tcw_pkg::ATTR_W-1:0]        attr,
    // result transactions
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tcw_pkg::POS_W-1:0]         position,
    output logic                              error,
    output logic [tcw_pkg::CHAR_W-1:0]        read_char,
    output logic [tcw_pkg::ATTR_W-1:0]        read_attr
);

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    tcw_pkg::cfg_t    cfg_reg;
    tcw_pkg::item_t   item;
    tcw_pkg::result_t res;
    tcw_pkg::result_t res_reg;
    logic             res_valid;
    logic             res_ready;
    logic             out_valid_reg;

    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [tcw_pkg::CELL_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [tcw_pkg::CELL_W-1:0] ram_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.default_attr <= tcw_pkg::DEFAULT_ATTR_RST;
            cfg_reg.error_attr   <= tcw_pkg::ERROR_ATTR_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tcw_pkg::CFG_DEFAULT_ATTR: cfg_reg.default_attr <= cfg_data;
                tcw_pkg::CFG_ERROR_ATTR:   cfg_reg.error_attr   <= cfg_data;
            endcase
        end
    end

    // input transaction bundle
    assign item.op         = op;
    assign item.ch         = ch;
    assign item.col        = col;
    assign item.row        = row;
    assign item.use_cursor = use_cursor;
    assign item.attr       = attr;

    tcw_seq #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .item      (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result register
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = res_reg.position;
    assign error     = res_reg.error;
    assign read_char = res_reg.read_char;
    assign read_attr = res_reg.read_attr;

`ifndef SYNTHESIS
    // a result is only handed over into a free or draining output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && out_valid_reg && !out_ready) |=> out_valid_reg && $stable(res_reg))
        else $error("pending result overwritten");

    // no transaction is taken during the reset clearing pass
    a_init_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("input taken before screen clear finished");

    // an error result never carries cell contents
    a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error) |-> ((read_char == '0) && (read_attr == '0)))
        else $error("error result with read data");
`endif

endmodule

### bench/text_console_cell_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer_tb
// Self-checking bench for the text console cell writer. A mirror of the
// screen memory, the cursor and the attribute registers predicts the result
// of every accepted transaction, and a checker compares each result field by
// field in order. Directed tests cover field extremes, control characters,
// scroll, out-of-range cells, clear and the unused opcode. Random text
// streams then run under several attribute settings, with random gaps on
// both channels except in one steady-flow run.
// ----------------------------------------------------------------------------
module text_console_cell_writer_tb;

    localparam int COLS       = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = COLS * ROWS;
    localparam int MAX_CYCLES = 10_000_000;
    localparam logic [tcw_pkg::OP_W-1:0] OP_NOP = 2'd3;

    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           cfg_write  = 1'b0;
    logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
    logic                           in_valid   = 1'b0;
    logic                           in_ready;
    logic [tcw_pkg::OP_W-1:0]       op         = '0;
    logic [tcw_pkg::CHAR_W-1:0]     ch         = '0;
    logic [tcw_pkg::COORD_W-1:0]    col        = '0;
    logic [tcw_pkg::COORD_W-1:0]    row        = '0;
    logic                           use_cursor = 1'b0;
    logic [tcw_pkg::ATTR_W-1:0]     attr       = '0;
    logic                           out_valid;
    logic                           out_ready  = 1'b0;
    logic [tcw_pkg::POS_W-1:0]      position;
    logic                           error;
    logic [tcw_pkg::CHAR_W-1:0]     read_char;
    logic [tcw_pkg::ATTR_W-1:0]     read_attr;

    // mirror of the block state
    logic [tcw_pkg::CELL_W-1:0] screen_mirror [CELLS];
    int                         cursor_mirror;
    logic [tcw_pkg::ATTR_W-1:0] mirror_default_attr;
    logic [tcw_pkg::ATTR_W-1:0] mirror_error_attr;

    tcw_pkg::result_t expected_results [$];
    int               fail_count  = 0;
    int               cycle_count = 0;
    bit               steady_flow = 1'b0;

    text_console_cell_writer #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .ch        (ch),
        .col       (col),
        .row       (row),
        .use_cursor(use_cursor),
        .attr      (attr),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .position  (position),
        .error     (error),
        .read_char (read_char),
        .read_attr (read_attr)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic bit in_range(input tcw_pkg::item_t it);
        return (it.col < COLS) && (it.row < ROWS);
    endfunction

    // cursor cell after a put, before any scroll
    function automatic int put_target(input tcw_pkg::item_t it);
        int at;
        at = it.use_cursor ? cursor_mirror : it.row * COLS + it.col;
        if (it.ch == tcw_pkg::CH_NEWLINE)
            at = (at / COLS + 1) * COLS;
        else if (it.ch != tcw_pkg::CH_BACKSPACE)
            at = at + 1;
        return at;
    endfunction

    function automatic bit sweeps_screen(input tcw_pkg::item_t it);
        if (it.op == tcw_pkg::OP_CLEAR)
            return 1'b1;
        return (it.op == tcw_pkg::OP_PUT) && (it.use_cursor || in_range(it)) &&
               (put_target(it) >= CELLS);
    endfunction

    function automatic tcw_pkg::result_t console_step(input tcw_pkg::item_t it);
        tcw_pkg::result_t           r;
        logic [tcw_pkg::ATTR_W-1:0] a;
        int                         lin;
        int                         base;
        int                         at;
        r = '0;
        r.position = cursor_mirror[tcw_pkg::POS_W-1:0];
        lin = it.row * COLS + it.col;
        a = (it.attr == '0) ? mirror_default_attr : it.attr;
        case (it.op)
            tcw_pkg::OP_PUT:
                if (!it.use_cursor && !in_range(it))
                begin
                    screen_mirror[CELLS-1] = {mirror_error_attr, tcw_pkg::CH_ERROR};
                    r.error = 1'b1;
                    r.position = lin[tcw_pkg::POS_W-1:0];
                end
                else
                begin
                    base = it.use_cursor ? cursor_mirror : lin;
                    at = put_target(it);
                    if (it.ch == tcw_pkg::CH_BACKSPACE)
                        screen_mirror[base] = {a, tcw_pkg::CH_BLANK};
                    else if (it.ch != tcw_pkg::CH_NEWLINE)
                        screen_mirror[base] = {a, it.ch};
                    // scroll up one row
                    if (at >= CELLS)
                    begin
                        for (int i = 0; i < CELLS - COLS; i++)
                            screen_mirror[i] = screen_mirror[i + COLS];
                        for (int i = CELLS - COLS; i < CELLS; i++)
                            screen_mirror[i] = '0;
                        at = at - COLS;
                    end
                    cursor_mirror = at;
                    r.position = at[tcw_pkg::POS_W-1:0];
                end
            tcw_pkg::OP_READ:
                if (in_range(it))
                begin
                    r.read_char = screen_mirror[lin][tcw_pkg::CHAR_W-1:0];
                    r.read_attr = screen_mirror[lin][tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                end
                else
                begin
                    r.error = 1'b1;
                    r.position = lin[tcw_pkg::POS_W-1:0];
                end
            tcw_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen_mirror[i] = {mirror_default_attr, tcw_pkg::CH_BLANK};
                cursor_mirror = 0;
                r.position = '0;
            end
            default:
                ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------
    function automatic tcw_pkg::item_t console_item(
        input logic [tcw_pkg::OP_W-1:0]    o,
        input logic [tcw_pkg::CHAR_W-1:0]  c,
        input logic [tcw_pkg::COORD_W-1:0] x,
        input logic [tcw_pkg::COORD_W-1:0] y,
        input logic                        uc,
        input logic [tcw_pkg::ATTR_W-1:0]  a);
        tcw_pkg::item_t it;
        it.op = o;
        it.ch = c;
        it.col = x;
        it.row = y;
        it.use_cursor = uc;
        it.attr = a;
        return it;
    endfunction

    // one input transaction, with a random gap ahead of it
    task automatic send_item(input tcw_pkg::item_t it);
        if (!steady_flow && $urandom_range(0, 99) < 13)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (!steady_flow && $urandom_range(0, 99) < 13);
        end
        {op, ch, col, row, use_cursor, attr} <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        expected_results.push_back(console_step(it));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic set_attrs(input logic [tcw_pkg::ATTR_W-1:0] def_attr,
                             input logic [tcw_pkg::ATTR_W-1:0] err_attr);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= tcw_pkg::CFG_DEFAULT_ATTR;
        cfg_data  <= def_attr;
        @(posedge clk);
        cfg_index <= tcw_pkg::CFG_ERROR_ATTR;
        cfg_data  <= err_attr;
        @(posedge clk);
        cfg_write <= 1'b0;
        mirror_default_attr = def_attr;
        mirror_error_attr   = err_attr;
    endtask

    // output stalls
    always @(posedge clk)
        out_ready <= steady_flow || ($urandom_range(0, 99) >= 13);

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string field_name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, field_name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        tcw_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display({"%0t: unexpected result: expected none, ",
                          "actual pos %0d err %0d ch %0d at %0d"},
                         $time, position, error, read_char, read_attr);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("position", int'(want.position), int'(position));
                check_field("error", int'(want.error), int'(error));
                check_field("read_char", int'(want.read_char), int'(read_char));
                check_field("read_attr", int'(want.read_attr), int'(read_attr));
            end
        end
    end

    // ------------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------------
    task automatic test_read_after_reset();
        send_item(console_item(tcw_pkg::OP_READ, 8'h00, 8'd0, 8'd0, 1'b0, 8'h00));
        send_item(console_item(tcw_pkg::OP_READ, 8'hFF, 8'(COLS - 1), 8'(ROWS - 1),
                               1'b1, 8'hFF));
    endtask

    task automatic test_put_extremes();
        send_item(console_item(tcw_pkg::OP_PUT, 8'h00, 8'd0, 8'd0, 1'b0, 8'h00));
        send_item(console_item(tcw_pkg::OP_PUT, 8'hFF, 8'(COLS - 2), 8'(ROWS - 1),
                               1'b0, 8'hFF));
        send_item(console_item(tcw_pkg::OP_READ, 8'h00, 8'd0, 8'd0, 1'b0, 8'h00));
    endtask

    // last cell write, newline and backspace, with scroll on the bottom row
    task automatic test_control_chars();
        send_item(console_item(tcw_pkg::OP_PUT, 8'h41, 8'hFF, 8'hFF, 1'b1, 8'h80));
        send_item(console_item(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 8'd0, 8'd0,
                               1'b1, 8'h00));
        send_item(console_item(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 8'd0, 8'd0,
                               1'b1, 8'h00));
        send_item(console_item(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 8'd0, 8'd0,
                               1'b0, 8'h01));
        send_item(console_item(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 8'(COLS - 1), 8'd3,
                               1'b0, 8'h22));
        send_item(console_item(tcw_pkg::OP_READ, 8'h00, 8'(COLS - 2), 8'(ROWS - 3),
                               1'b0, 8'h00));
        send_item(console_item(tcw_pkg::OP_READ, 8'h00, 8'(COLS - 1), 8'(ROWS - 3),
                               1'b0, 8'h00));
    endtask

    task automatic test_out_of_range();
        send_item(console_item(tcw_pkg::OP_PUT, 8'h31, 8'(COLS), 8'd0, 1'b0, 8'h11));
        send_item(console_item(tcw_pkg::OP_PUT, 8'h32, 8'd0, 8'(ROWS), 1'b0, 8'h00));
        send_item(console_item(tcw_pkg::OP_PUT, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'hFF));
        send_item(console_item(tcw_pkg::OP_READ, 8'h00, 8'(COLS - 1), 8'(ROWS - 1),
                               1'b0, 8'h00));
        send_item(console_item(tcw_pkg::OP_READ, 8'h00, 8'(COLS), 8'(ROWS), 1'b0, 8'h00));
        send_item(console_item(tcw_pkg::OP_READ, 8'h00, 8'hFF, 8'd0, 1'b1, 8'h00));
    endtask

    task automatic test_unused_op();
        send_item(console_item(OP_NOP, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF));
    endtask

    task automatic test_clear_screen();
        send_item(console_item(tcw_pkg::OP_CLEAR, 8'h55, 8'd7, 8'd7, 1'b0, 8'h33));
        send_item(console_item(tcw_pkg::OP_READ, 8'h00, 8'd0, 8'd0, 1'b0, 8'h00));
        send_item(console_item(tcw_pkg::OP_READ, 8'h00, 8'(COLS - 1), 8'(ROWS - 1),
                               1'b0, 8'h00));
    endtask

    // ------------------------------------------------------------------------
    // random text streams
    // ------------------------------------------------------------------------
    function automatic tcw_pkg::item_t random_item();
        tcw_pkg::item_t it;
        int             kind;
        logic [63:0]    raw;
        it.op = tcw_pkg::OP_PUT;
        it.ch = 8'($urandom_range(32, 126));
        it.col = 8'($urandom_range(0, 255));
        it.row = 8'($urandom_range(0, 255));
        it.use_cursor = 1'b1;
        it.attr = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        kind = $urandom_range(0, 99);
        if (kind < 60)
        begin
            // text at the cursor
            if ($urandom_range(0, 99) < 8)
                it.ch = tcw_pkg::CH_NEWLINE;
            else if ($urandom_range(0, 99) < 5)
                it.ch = tcw_pkg::CH_BACKSPACE;
        end
        else if (kind < 70)
        begin
            // reposition with an explicit put
            it.use_cursor = 1'b0;
            it.col = 8'($urandom_range(0, COLS - 1));
            it.row = 8'($urandom_range(0, ROWS - 1));
            it.ch = 8'($urandom_range(0, 255));
        end
        else if (kind < 85)
        begin
            it.op = tcw_pkg::OP_READ;
            it.use_cursor = 1'($urandom_range(0, 1));
            it.col = 8'($urandom_range(0, COLS - 1));
            it.row = 8'($urandom_range(0, ROWS - 1));
        end
        else if (kind < 90)
        begin
            it.op = $urandom_range(0, 1) ? tcw_pkg::OP_READ : tcw_pkg::OP_PUT;
            it.use_cursor = 1'b0;
            if ($urandom_range(0, 1))
                it.col = 8'($urandom_range(COLS, 255));
            else
                it.row = 8'($urandom_range(ROWS, 255));
        end
        else if (kind < 95)
        begin
            raw = {$urandom, $urandom};
            it = raw[$bits(tcw_pkg::item_t)-1:0];
        end
        else if (kind < 98)
            it.op = OP_NOP;
        else
            it.op = tcw_pkg::OP_CLEAR;
        return it;
    endfunction

    // most full-screen sweeps are thinned out to keep the run short
    task automatic run_random_text(input int count);
        tcw_pkg::item_t it;
        repeat (count)
        begin
            do
                it = random_item();
            while (sweeps_screen(it) && $urandom_range(0, 99) >= 25);
            send_item(it);
        end
    endtask

    task automatic test_random_text();
        set_attrs(8'h00, 8'hFF);
        run_random_text(260);
        set_attrs(8'hFF, 8'h00);
        run_random_text(260);
        set_attrs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        steady_flow = 1'b1;
        run_random_text(260);
        steady_flow = 1'b0;
        set_attrs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_random_text(260);
        set_attrs(tcw_pkg::DEFAULT_ATTR_RST, tcw_pkg::ERROR_ATTR_RST);
        run_random_text(260);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        foreach (screen_mirror[i])
            screen_mirror[i] = '0;
        cursor_mirror = 0;
        mirror_default_attr = tcw_pkg::DEFAULT_ATTR_RST;
        mirror_error_attr = tcw_pkg::ERROR_ATTR_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_read_after_reset();
        test_put_extremes();
        test_control_chars();
        test_out_of_range();
        test_unused_op();
        test_clear_screen();
        test_random_text();

        // drain, then leave room for a trailing sweep
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (CELLS + 8) @(posedge clk);
        if (fail_count == 0)
            $display("text_console_cell_writer verification clean");
        else
            $display("text_console_cell_writer verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        while (cycle_count < MAX_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("text_console_cell_writer verification failed");
        $finish;
    end

endmodule

### text_console_cell_writer.f
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_seq.sv
hdl/text_console_cell_writer.sv
bench/text_console_cell_writer_tb.sv
